### sv/dnd_pkg.sv
package dnd_pkg;

	localparam int POS_W  = 9;
	localparam int BYTE_W = 8;

	// command codes handed from the front end to the walker
	localparam logic [1:0] OP_NOP    = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_DECODE = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_TOO_LONG = 2'd1;
	localparam logic [1:0] STAT_JUMPS    = 2'd2;
	localparam logic [1:0] STAT_RANGE    = 2'd3;

	localparam logic [7:0] PTR_MARK = 8'd192;
	localparam logic [7:0] DOT_CHAR = 8'h2E;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef struct packed {
		logic [1:0]        op;
		logic [POS_W-1:0]  pos;
		logic [BYTE_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [8:0]  consumed;
		logic        last;
		logic [3:0]  count;
		logic [63:0] chars;
	} res_t;

endpackage

### sv/dnd_front.sv
module dnd_front #(
	parameter int PKT_DEPTH = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_func,
	input  logic [8:0]           in_pos,
	input  logic [7:0]           in_byte,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output dnd_pkg::cmd_t        cmd
);
	import dnd_pkg::*;

	logic front_valid_q;
	cmd_t cmd_q;
	logic in_range;

	assign in_range  = 32'(in_pos) < PKT_DEPTH;
	assign in_ready  = !front_valid_q || cmd_ready;
	assign cmd_valid = front_valid_q;
	assign cmd       = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			front_valid_q <= 1'b1;
		end else if (cmd_ready) begin
			front_valid_q <= 1'b0;
		end
	end

	// writes past the store are dropped here
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			if (in_func)
				cmd_q.op <= OP_DECODE;
			else if (in_range)
				cmd_q.op <= OP_WRITE;
			else
				cmd_q.op <= OP_NOP;
			cmd_q.pos  <= in_pos;
			cmd_q.data <= in_byte;
		end
	end

endmodule

### sv/dnd_fifo.sv
module dnd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          push_ready,
	input  dnd_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop,
	output dnd_pkg::cmd_t pop_cmd
);
	import dnd_pkg::*;

	cmd_t              slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != (QPTR_W+1)'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = slots_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_cmd;
	end

endmodule

### sv/dnd_back.sv
module dnd_back #(
	parameter int PKT_DEPTH = 512,
	parameter int NAME_MAX  = 255,
	parameter int MAX_JUMPS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	input  dnd_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output dnd_pkg::res_t res
);
	import dnd_pkg::*;

	localparam int ADDR_W = $clog2(PKT_DEPTH);
	localparam int CUR_W  = ((ADDR_W > 14) ? ADDR_W : 14) + 1;
	localparam logic [CUR_W-1:0] DEPTH_C = CUR_W'(PKT_DEPTH);
	localparam logic [7:0]       NMAX_C  = 8'(NAME_MAX);
	localparam logic [4:0]       JMAX_C  = 5'(MAX_JUMPS);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FETCH  = 3'd1;
	localparam logic [2:0] S_HEAD   = 3'd2;
	localparam logic [2:0] S_PTR    = 3'd3;
	localparam logic [2:0] S_LFETCH = 3'd4;
	localparam logic [2:0] S_LBYTE  = 3'd5;
	localparam logic [2:0] S_FINAL  = 3'd6;

	logic [7:0]        store [PKT_DEPTH];
	logic [7:0]        rdata_q;

	logic [2:0]        state_q;
	logic [CUR_W-1:0]  cur_q;
	logic              jumped_q;
	logic [8:0]        walked_q;
	logic [7:0]        text_len_q;
	logic [4:0]        jump_cnt_q;
	logic [7:0]        label_rem_q;
	logic [5:0]        ptr_hi_q;
	logic [63:0]       buf_q;
	logic [3:0]        fill_q;
	logic [1:0]        status_q;
	logic              res_valid_q;
	res_t              res_q;

	logic [CUR_W-1:0]  cur_inc;
	logic              slot_free;
	logic              buf_full;
	logic              at_end;
	logic              inc_end;
	logic              is_ptr;
	logic              mem_re;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_raddr;
	logic              load_chunk;
	logic              load_final;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		cur_inc    = cur_q + 1'b1;
		slot_free  = !res_valid_q || res_ready;
		buf_full   = fill_q == 4'd8;
		at_end     = cur_q >= DEPTH_C;
		inc_end    = cur_inc >= DEPTH_C;
		is_ptr     = rdata_q >= PTR_MARK;
		load_chunk = buf_full && slot_free;
		load_final = (state_q == S_FINAL) && !buf_full && slot_free;
		cmd_pop    = (state_q == S_IDLE) && cmd_valid;
		mem_we     = cmd_pop && (cmd.op == OP_WRITE);
		mem_re     = ((state_q == S_FETCH) && !at_end)
			|| ((state_q == S_HEAD) && !buf_full && is_ptr && !inc_end)
			|| ((state_q == S_LFETCH) && (label_rem_q != 8'd0) && !at_end);
		mem_raddr  = (state_q == S_HEAD) ? cur_inc[ADDR_W-1:0] : cur_q[ADDR_W-1:0];
	end

	// packet store, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			store[ADDR_W'(cmd.pos)] <= cmd.data;
		if (mem_re)
			rdata_q <= store[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			fill_q      <= '0;
			buf_q       <= '0;
			label_rem_q <= '0;
			jump_cnt_q  <= '0;
		end else begin
			if (load_chunk || load_final)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;

			// full eight-char chunk goes out as soon as the output slot frees up
			if (load_chunk) begin
				res_q       <= '{status: STAT_OK, consumed: 9'd0, last: 1'b0,
					count: 4'd8, chars: buf_q};
				buf_q       <= '0;
				fill_q      <= '0;
			end

			case (state_q)
				S_IDLE: begin
					if (cmd_valid && (cmd.op == OP_DECODE)) begin
						cur_q       <= CUR_W'(cmd.pos);
						jumped_q    <= 1'b0;
						walked_q    <= '0;
						text_len_q  <= '0;
						jump_cnt_q  <= '0;
						label_rem_q <= '0;
						status_q    <= STAT_OK;
						buf_q       <= '0;
						fill_q      <= '0;
						state_q     <= S_FETCH;
					end
				end
				S_FETCH: begin
					if (at_end) begin
						status_q <= STAT_RANGE;
						state_q  <= S_FINAL;
					end else begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					if (!buf_full) begin
						if (rdata_q == 8'd0) begin
							if (!jumped_q)
								walked_q <= walked_q + 1'b1;
							state_q <= S_FINAL;
						end else if (is_ptr) begin
							if (inc_end) begin
								status_q <= STAT_RANGE;
								state_q  <= S_FINAL;
							end else begin
								if (!jumped_q) begin
									walked_q <= walked_q + 9'd2;
									jumped_q <= 1'b1;
								end
								if (jump_cnt_q >= JMAX_C) begin
									status_q <= STAT_JUMPS;
									state_q  <= S_FINAL;
								end else begin
									jump_cnt_q <= jump_cnt_q + 1'b1;
									ptr_hi_q   <= rdata_q[5:0];
									state_q    <= S_PTR;
								end
							end
						end else begin
							label_rem_q <= rdata_q;
							cur_q       <= cur_inc;
							if (!jumped_q)
								walked_q <= walked_q + 1'b1;
							if (text_len_q != 8'd0) begin
								if (text_len_q >= NMAX_C) begin
									status_q <= STAT_TOO_LONG;
									state_q  <= S_FINAL;
								end else begin
									buf_q[{fill_q[2:0], 3'b000} +: 8] <= DOT_CHAR;
									fill_q     <= fill_q + 1'b1;
									text_len_q <= text_len_q + 1'b1;
									state_q    <= S_LFETCH;
								end
							end else begin
								state_q <= S_LFETCH;
							end
						end
					end
				end
				S_PTR: begin
					// low 14 bits of the two pointer bytes
					cur_q   <= CUR_W'({ptr_hi_q, rdata_q});
					state_q <= S_FETCH;
				end
				S_LFETCH: begin
					if (label_rem_q == 8'd0) begin
						state_q <= S_FETCH;
					end else if (at_end) begin
						status_q <= STAT_RANGE;
						state_q  <= S_FINAL;
					end else begin
						state_q <= S_LBYTE;
					end
				end
				S_LBYTE: begin
					if (!buf_full) begin
						if (text_len_q >= NMAX_C) begin
							status_q <= STAT_TOO_LONG;
							state_q  <= S_FINAL;
						end else begin
							buf_q[{fill_q[2:0], 3'b000} +: 8] <= rdata_q;
							fill_q      <= fill_q + 1'b1;
							text_len_q  <= text_len_q + 1'b1;
							cur_q       <= cur_inc;
							label_rem_q <= label_rem_q - 1'b1;
							if (!jumped_q)
								walked_q <= walked_q + 1'b1;
							state_q <= S_LFETCH;
						end
					end
				end
				S_FINAL: begin
					if (load_final) begin
						res_q       <= '{status: status_q, consumed: walked_q, last: 1'b1,
							count: fill_q, chars: buf_q};
						buf_q       <= '0;
						fill_q      <= '0;
						label_rem_q <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/dns_name_decompressor.sv
// DNS compressed-name decoder. Each slave-side transfer is either a load
// (tuser 0) that writes one packet byte into an internal store of PKT_DEPTH
// bytes, or a decode (tuser 1) that walks the name starting at the given
// offset: length-prefixed labels, compression pointers (two bytes starting
// at 192 or more, low 14 bits give the target), zero byte ends the name.
// The name comes out as dotted text, eight characters per master-side
// transfer, first character in the low byte, no trailing dot; the final
// transfer has tlast set and carries the 0..7 leftover characters, the
// bytes the name occupies at its start offset, and a status (0 ok, 1 longer
// than NAME_MAX, 2 more than MAX_JUMPS pointers, 3 read or pointer outside
// the store). A root name gives one empty final transfer. A load writes its
// byte into the store as the walker takes the command. A decode reads each
// length or label byte through the store's one registered read port, in a
// fetch state and then a state that uses the byte; a pointer passes through
// a state that loads its target, and a final state hands out the result.
// Full eight-character results leave alongside the walk and stall it only
// while the output register is still held. Input transfers queue up in the
// front register and a four-entry command buffer while a decode runs, and a
// finished result waits in an output register so the walker keeps going.
module dns_name_decompressor #(
	parameter int PKT_DEPTH = 512,
	parameter int NAME_MAX  = 255,
	parameter int MAX_JUMPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // position[8:0], byte_value[16:9], zero pad
	input  logic        s_tuser,   // func: 0 load byte, 1 decode name

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // name_chars[63:0], char_count[67:64],
	                               // consumed[76:68], status[78:77], zero pad
	output logic        m_tlast    // last result of a decode
);
	import dnd_pkg::*;

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;
	res_t res;

	// front end: registers and classifies each transfer
	dnd_front #(
		.PKT_DEPTH(PKT_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_func  (s_tuser),
		.in_pos   (s_tdata[8:0]),
		.in_byte  (s_tdata[16:9]),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	// command queue between front and walker
	dnd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_valid),
		.push_ready(cmd_ready),
		.push_cmd  (cmd),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_cmd   (q_cmd)
	);

	// walker: packet store, label/pointer walk, result register
	dnd_back #(
		.PKT_DEPTH(PKT_DEPTH),
		.NAME_MAX (NAME_MAX),
		.MAX_JUMPS(MAX_JUMPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_valid),
		.cmd_pop  (q_pop),
		.cmd      (q_cmd),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res      (res)
	);

	assign m_tdata = {1'b0, res.status, res.consumed, res.count, res.chars};
	assign m_tlast = res.last;

endmodule
